@@ src/gst_pkg.sv @@
// shared constants, types and command codes for the generational slot table
package gst_pkg;
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int FAMILIES_DEF  = 8;
    localparam int GEN_BITS_DEF  = 32;
    localparam int MAX_RESULTS   = 8;
    localparam int DENS_W        = 16;
    localparam int SUM_W         = 26;
    localparam int CNT_W         = 11;
    localparam int SLOT_W        = 10;
    localparam int GEN_W         = 32;
    localparam int FAM_W         = 3;

    localparam logic [2:0] KIND_SPAWN   = 3'd0;
    localparam logic [2:0] KIND_KILL    = 3'd1;
    localparam logic [2:0] KIND_LOSS    = 3'd2;
    localparam logic [2:0] KIND_COMPACT = 3'd3;
    localparam logic [2:0] KIND_RESOLVE = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [GEN_W-1:0]  generation_out;
        logic [CNT_W-1:0]  live_count;
        logic [SUM_W-1:0]  total_density;
        logic [CNT_W-1:0]  removed_total;
        logic [FAM_W-1:0]  result_family;
        logic [CNT_W-1:0]  family_removed;
        logic [CNT_W-1:0]  family_live;
        logic              last;
    } result_t;
endpackage

@@ src/gst_out_reg.sv @@
// output register stage holding one result beat
module gst_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  gst_pkg::result_t    data_in,
    output logic                full,
    input  logic                take,
    output gst_pkg::result_t    data_out
);
    logic             full_reg;
    gst_pkg::result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (load) begin
            full_reg <= 1'b1;
        end else if (take) begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

    assign full     = full_reg;
    assign data_out = data_reg;

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!full_reg || take)) else $error("result overwritten");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (full_reg && !take && !load) |=> $stable(data_reg)) else $error("data moved");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> full_reg) else $error("full lost");
`endif
endmodule

@@ src/generational_slot_table_core.sv @@
// top level of the generational slot table: sequencer, slot memories and output stage
//
//  channel | ports                 | dir
//  s_      | valid/ready + fields  | in
//  m_      | valid/ready + fields  | out
//  cfg     | cfg_we, cfg_data      | in
//
// spawn, clear, rejected items: decode then emit, the result held in the output register
// kill, loss: the slot is read then written back
// resolve: the indexed slot is tested first; on a miss the live entries are scanned
// compact: slots up to the live count are visited, removals refilled from the last slot;
// one beat per family, at most MAX_RESULTS beats; reset is synchronous; memories are not
// cleared, the live count bounds reads; a stalled result holds the sequencer in its emit state
module generational_slot_table_core #(
    parameter int MAX_SLOTS = gst_pkg::MAX_SLOTS_DEF,
    parameter int FAMILIES  = gst_pkg::FAMILIES_DEF,
    parameter int GEN_BITS  = gst_pkg::GEN_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [gst_pkg::CNT_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_kind,
    input  logic [gst_pkg::SLOT_W-1:0] s_slot_index,
    input  logic [gst_pkg::GEN_W-1:0]  s_handle_generation,
    input  logic [gst_pkg::FAM_W-1:0]  s_family_in,
    input  logic [gst_pkg::DENS_W-1:0] s_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [gst_pkg::SLOT_W-1:0] m_slot_out,
    output logic [gst_pkg::GEN_W-1:0]  m_generation_out,
    output logic [gst_pkg::CNT_W-1:0]  m_live_count,
    output logic [gst_pkg::SUM_W-1:0]  m_total_density,
    output logic [gst_pkg::CNT_W-1:0]  m_removed_total,
    output logic [2:0]                 m_result_family,
    output logic [gst_pkg::CNT_W-1:0]  m_family_removed,
    output logic [gst_pkg::CNT_W-1:0]  m_family_live,
    output logic                       m_last
);
    localparam int AW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int FW  = (FAMILIES > 1) ? $clog2(FAMILIES) : 1;
    localparam int NR  = (FAMILIES < gst_pkg::MAX_RESULTS) ? FAMILIES : gst_pkg::MAX_RESULTS;
    localparam int NRW = (NR > 1) ? $clog2(NR) : 1;
    localparam int EW  = GEN_BITS + gst_pkg::FAM_W + gst_pkg::DENS_W + 1;
    localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);
    localparam logic [gst_pkg::SUM_W-1:0] SUM_MAX = '1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LRD    = 4'd2;
    localparam logic [3:0] S_LUPD   = 4'd3;
    localparam logic [3:0] S_RHIT   = 4'd4;
    localparam logic [3:0] S_RSCAN  = 4'd5;
    localparam logic [3:0] S_RTEST  = 4'd6;
    localparam logic [3:0] S_CRD    = 4'd7;
    localparam logic [3:0] S_CTEST  = 4'd8;
    localparam logic [3:0] S_CMOVE  = 4'd9;
    localparam logic [3:0] S_CPUT   = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_CEMIT  = 4'd12;

    // entry memory: {generation, family, density, pending}
    logic [EW-1:0] mem [MAX_SLOTS];
    logic [EW-1:0] rd_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    logic [GEN_BITS-1:0]        rd_gen;
    logic [gst_pkg::FAM_W-1:0]  rd_fam;
    logic [gst_pkg::DENS_W-1:0] rd_dens;
    logic                       rd_pend;
    assign {rd_gen, rd_fam, rd_dens, rd_pend} = rd_reg;

    logic [3:0]                 state_reg, state_next;

    logic [gst_pkg::CNT_W-1:0]  cap_reg;
    logic [CW-1:0]              live_reg;
    logic [GEN_BITS-1:0]        ngen_reg;
    logic [gst_pkg::SUM_W-1:0]  sum_reg;
    logic [gst_pkg::CNT_W-1:0]  fcnt_reg [FAMILIES];
    logic [gst_pkg::CNT_W-1:0]  frem_reg [FAMILIES];
    logic [gst_pkg::CNT_W-1:0]  removed_reg;
    logic [CW-1:0]              idx_reg;
    logic [NRW-1:0]             emit_reg;
    logic [2:0]                 kind_reg;
    logic [gst_pkg::SLOT_W-1:0] sidx_reg;
    logic [gst_pkg::GEN_W-1:0]  hgen_reg;
    logic [gst_pkg::FAM_W-1:0]  fam_reg;
    logic [gst_pkg::DENS_W-1:0] amt_reg;
    gst_pkg::result_t           res_reg;

    logic             ob_full, ob_load;
    gst_pkg::result_t ob_data;
    gst_pkg::result_t res_out;

    logic [CW-1:0] cap_eff;
    assign cap_eff = (cap_reg > gst_pkg::CNT_W'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cap_reg);

    // shared compare/subtract unit
    logic [gst_pkg::SUM_W-1:0] sub_op, sub_res;
    assign sub_res = (sub_op > sum_reg) ? '0 : sum_reg - sub_op;

    logic [gst_pkg::SUM_W:0]    add_full;
    assign add_full = {1'b0, sum_reg} + (gst_pkg::SUM_W+1)'(amt_reg);

    logic [GEN_BITS-1:0] gen_inc;
    assign gen_inc = (ngen_reg + GEN_ONE == '0) ? GEN_ONE : ngen_reg + GEN_ONE;

    logic [gst_pkg::GEN_W-1:0] rd_gen32;
    assign rd_gen32 = gst_pkg::GEN_W'(rd_gen);
    logic gen_match;
    assign gen_match = (rd_gen32 == hgen_reg)
                     && (GEN_BITS >= gst_pkg::GEN_W || (hgen_reg >> GEN_BITS) == '0);

    assign s_ready = (state_reg == S_IDLE);

    function automatic gst_pkg::result_t simple(input logic [1:0] st,
            input logic [gst_pkg::SLOT_W-1:0] sl, input logic [gst_pkg::GEN_W-1:0] g);
        gst_pkg::result_t r;
        r = '0;
        r.status = st;
        r.slot_out = sl;
        r.generation_out = g;
        r.last = 1'b1;
        return r;
    endfunction

    logic [FW-1:0] rfam;
    assign rfam = FW'(rd_fam);
    logic rfam_ok;
    assign rfam_ok = (32'(rd_fam) < FAMILIES);

    logic [CW-1:0] lastslot;
    assign lastslot = live_reg - CW'(1);

    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = rd_reg;
        raddr = idx_reg[AW-1:0];
        sub_op = '0;
        ob_load = 1'b0;
        ob_data = res_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_DECODE;
            S_DECODE: state_next = S_EMIT;
            S_LRD: state_next = S_LUPD;
            S_LUPD: state_next = S_EMIT;
            S_RHIT: state_next = S_RSCAN;
            S_RSCAN: state_next = S_RTEST;
            S_RTEST: state_next = S_RSCAN;
            S_CRD: state_next = S_CTEST;
            S_CTEST: state_next = S_CRD;
            S_CMOVE: state_next = S_CPUT;
            S_CPUT: state_next = S_CRD;
            S_EMIT: if (!ob_full || m_ready) begin
                ob_load = 1'b1;
                state_next = S_IDLE;
            end
            S_CEMIT: if (!ob_full || m_ready) begin
                ob_load = 1'b1;
                if (emit_reg == NRW'(NR - 1)) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DECODE) begin
            unique case (kind_reg)
                gst_pkg::KIND_SPAWN: if (live_reg < cap_eff) begin
                    we = 1'b1;
                    waddr = live_reg[AW-1:0];
                    wdata = {ngen_reg, fam_reg, amt_reg, 1'b0};
                end
                gst_pkg::KIND_KILL: if (32'(sidx_reg) < 32'(live_reg))
                    state_next = S_LRD;
                gst_pkg::KIND_LOSS: if (32'(sidx_reg) < 32'(live_reg) && amt_reg != '0)
                    state_next = S_LRD;
                gst_pkg::KIND_COMPACT: state_next = S_CRD;
                gst_pkg::KIND_RESOLVE: if (hgen_reg != '0) state_next = S_RHIT;
                default: ;
            endcase
            raddr = AW'(sidx_reg);
        end
        if (state_reg == S_LRD) raddr = AW'(sidx_reg);
        if (state_reg == S_LUPD) begin
            we = 1'b1;
            waddr = AW'(sidx_reg);
            if (kind_reg == gst_pkg::KIND_LOSS) begin
                sub_op = gst_pkg::SUM_W'((amt_reg < rd_dens) ? amt_reg : rd_dens);
                wdata = {rd_gen, rd_fam, rd_dens - sub_op[gst_pkg::DENS_W-1:0],
                         rd_pend || (amt_reg >= rd_dens)};
            end else begin
                wdata = {rd_gen, rd_fam, rd_dens, 1'b1};
            end
        end
        if (state_reg == S_RHIT) begin
            if (32'(sidx_reg) < 32'(live_reg) && gen_match) state_next = S_EMIT;
        end
        if (state_reg == S_RSCAN) begin
            if (idx_reg >= live_reg) state_next = S_EMIT;
        end
        if (state_reg == S_RTEST && gen_match) state_next = S_EMIT;
        if (state_reg == S_CRD) begin
            if (idx_reg >= live_reg) state_next = S_CEMIT;
        end
        if (state_reg == S_CTEST) begin
            sub_op = gst_pkg::SUM_W'(rd_dens);
            if (rd_pend) begin
                state_next = S_CMOVE;
            end
            raddr = lastslot[AW-1:0];
        end
        if (state_reg == S_CMOVE) raddr = lastslot[AW-1:0];
        if (state_reg == S_CPUT) begin
            if (idx_reg != live_reg) begin
                we = 1'b1;
                waddr = idx_reg[AW-1:0];
                wdata = rd_reg;
            end
        end
        if (state_reg == S_CEMIT) begin
            ob_data = '0;
            ob_data.removed_total = removed_reg;
            ob_data.result_family = gst_pkg::FAM_W'(emit_reg);
            ob_data.family_removed = frem_reg[emit_reg];
            ob_data.family_live = fcnt_reg[emit_reg];
            ob_data.last = (emit_reg == NRW'(NR - 1));
        end
        ob_data.live_count = gst_pkg::CNT_W'(live_reg);
        ob_data.total_density = sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg <= gst_pkg::CNT_W'(1024);
            live_reg <= '0;
            ngen_reg <= GEN_ONE;
            sum_reg <= '0;
            for (int f = 0; f < FAMILIES; f++) fcnt_reg[f] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) cap_reg <= cfg_data;
            if (state_reg == S_DECODE) begin
                unique case (kind_reg)
                    gst_pkg::KIND_SPAWN: if (live_reg < cap_eff) begin
                        live_reg <= live_reg + CW'(1);
                        ngen_reg <= gen_inc;
                        sum_reg <= add_full[gst_pkg::SUM_W] ? SUM_MAX
                                                            : add_full[gst_pkg::SUM_W-1:0];
                        if (32'(fam_reg) < FAMILIES)
                            fcnt_reg[FW'(fam_reg)] <= fcnt_reg[FW'(fam_reg)]
                                                      + gst_pkg::CNT_W'(1);
                    end
                    gst_pkg::KIND_CLEAR: begin
                        live_reg <= '0;
                        sum_reg <= '0;
                        for (int f = 0; f < FAMILIES; f++) fcnt_reg[f] <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_LUPD) sum_reg <= sub_res;
            if (state_reg == S_CTEST && rd_pend) begin
                sum_reg <= sub_res;
                if (rfam_ok && fcnt_reg[rfam] != '0)
                    fcnt_reg[rfam] <= fcnt_reg[rfam] - gst_pkg::CNT_W'(1);
            end
            if (state_reg == S_CMOVE) live_reg <= lastslot;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg <= s_kind;
            sidx_reg <= s_slot_index;
            hgen_reg <= s_handle_generation;
            fam_reg  <= s_family_in;
            amt_reg  <= s_amount;
            idx_reg  <= '0;
            emit_reg <= '0;
            removed_reg <= '0;
            for (int f = 0; f < FAMILIES; f++) frem_reg[f] <= '0;
        end
        unique case (state_reg)
            S_DECODE: begin
                unique case (kind_reg)
                    gst_pkg::KIND_SPAWN:
                        res_reg <= (live_reg < cap_eff)
                            ? simple(gst_pkg::ST_OK, gst_pkg::SLOT_W'(live_reg),
                                     gst_pkg::GEN_W'(ngen_reg))
                            : simple(gst_pkg::ST_FULL, '0, '0);
                    gst_pkg::KIND_KILL:
                        res_reg <= (32'(sidx_reg) < 32'(live_reg))
                            ? simple(gst_pkg::ST_OK, '0, '0)
                            : simple(gst_pkg::ST_IGNORED, '0, '0);
                    gst_pkg::KIND_LOSS:
                        res_reg <= (32'(sidx_reg) < 32'(live_reg) && amt_reg != '0)
                            ? simple(gst_pkg::ST_OK, '0, '0)
                            : simple(gst_pkg::ST_IGNORED, '0, '0);
                    gst_pkg::KIND_CLEAR:
                        res_reg <= simple(gst_pkg::ST_OK, '0, '0);
                    gst_pkg::KIND_RESOLVE:
                        res_reg <= (hgen_reg != '0)
                            ? simple(gst_pkg::ST_MISSING, '0, '0)
                            : simple(gst_pkg::ST_IGNORED, '0, '0);
                    default:
                        res_reg <= simple(gst_pkg::ST_IGNORED, '0, '0);
                endcase
            end
            S_RHIT: if (32'(sidx_reg) < 32'(live_reg) && gen_match)
                res_reg <= simple(gst_pkg::ST_OK, sidx_reg, '0);
            S_RSCAN: idx_reg <= idx_reg + CW'(1);
            S_RTEST: if (gen_match)
                res_reg <= simple(gst_pkg::ST_OK, gst_pkg::SLOT_W'(idx_reg - CW'(1)), '0);
            S_CTEST: if (rd_pend) begin
                removed_reg <= removed_reg + gst_pkg::CNT_W'(1);
                if (rfam_ok) frem_reg[rfam] <= frem_reg[rfam] + gst_pkg::CNT_W'(1);
            end else begin
                idx_reg <= idx_reg + CW'(1);
            end
            S_CEMIT: if (!ob_full || m_ready) emit_reg <= emit_reg + NRW'(1);
            default: ;
        endcase
    end

    gst_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (ob_load),
        .data_in (ob_data),
        .full    (ob_full),
        .take    (m_ready),
        .data_out(res_out)
    );

    assign m_valid          = ob_full;
    assign m_status         = res_out.status;
    assign m_slot_out       = res_out.slot_out;
    assign m_generation_out = res_out.generation_out;
    assign m_live_count     = res_out.live_count;
    assign m_total_density  = res_out.total_density;
    assign m_removed_total  = res_out.removed_total;
    assign m_result_family  = res_out.result_family;
    assign m_family_removed = res_out.family_removed;
    assign m_family_live    = res_out.family_live;
    assign m_last           = res_out.last;

`ifndef SYNTH
    a_live_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CW'(MAX_SLOTS)) else $error("live count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_gen_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        ngen_reg != '0) else $error("generation zero");
`endif
endmodule
